/* design/tfb_pkg.sv */
package tfb_pkg;

  localparam int unsigned PaddrWidth = 4;
  localparam int unsigned PdataWidth = 32;

  localparam logic [1:0] RegHeadByte = 2'd0;
  localparam logic [1:0] RegSrcAddr  = 2'd1;
  localparam logic [1:0] RegDstAddr  = 2'd2;

  localparam logic [7:0] HeadByteReset = 8'hAB;

  localparam int unsigned CountWidth = 17;

  typedef struct packed {
    logic [7:0] head_byte;
    logic [7:0] src_addr;
    logic [7:0] dst_addr;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  func_code;
    logic [15:0] payload_len;
    logic [7:0]  data_byte;
    logic        has_byte;
    logic        end_of_payload;
  } item_t;

  typedef struct packed {
    logic  vld;
    item_t item;
  } held_t;

endpackage

/* design/tfb_cfg_regs.sv */
module tfb_cfg_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [tfb_pkg::PaddrWidth-1:0]     paddr,
  input  logic [tfb_pkg::PdataWidth-1:0]     pwdata,
  output logic [tfb_pkg::PdataWidth-1:0]     prdata,
  output logic                               pready,
  output tfb_pkg::cfg_t                      cfg_o
);

  tfb_pkg::cfg_t cfg_q;
  logic [1:0]    idx;
  logic          wr;

  assign idx    = paddr[3:2];
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.head_byte <= tfb_pkg::HeadByteReset;
      cfg_q.src_addr  <= 8'd0;
      cfg_q.dst_addr  <= 8'd0;
    end else if (wr) begin
      case (idx)
        tfb_pkg::RegHeadByte: cfg_q.head_byte <= pwdata[7:0];
        tfb_pkg::RegSrcAddr:  cfg_q.src_addr  <= pwdata[7:0];
        tfb_pkg::RegDstAddr:  cfg_q.dst_addr  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      tfb_pkg::RegHeadByte: prdata[7:0] = cfg_q.head_byte;
      tfb_pkg::RegSrcAddr:  prdata[7:0] = cfg_q.src_addr;
      tfb_pkg::RegDstAddr:  prdata[7:0] = cfg_q.dst_addr;
      default:              prdata = '0;
    endcase
  end

endmodule

/* design/tfb_in_reg.sv */
module tfb_in_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  tfb_pkg::item_t item_i,
  input  logic           done_i,
  output tfb_pkg::held_t held_o
);

  logic           vld_q;
  tfb_pkg::item_t item_q;
  logic           take;

  // slot frees up in the same cycle the held item finishes
  assign in_stall_o = vld_q & ~done_i;
  assign take       = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (take) begin
      vld_q <= 1'b1;
    end else if (done_i) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_i;
    end
  end

  assign held_o.vld  = vld_q;
  assign held_o.item = item_q;

endmodule

/* design/tfb_framer.sv */
module tfb_framer (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tfb_pkg::cfg_t  cfg_i,
  input  tfb_pkg::held_t held_i,
  output logic           done_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [7:0]     out_byte_o,
  output logic           frame_end_o,
  output logic           length_error_o
);

  typedef enum logic [3:0] {
    S_START,
    S_HDR0,
    S_HDR1,
    S_HDR2,
    S_HDR3,
    S_HDR4,
    S_HDR5,
    S_DATA,
    S_SUM,
    S_ADD,
    S_NONE
  } slot_e;

  slot_e                            slot_q, slot_d, cur, nxt;
  logic                             in_frame_q, in_frame_d;
  logic [7:0]                       sum_q, sum_d, add_q, add_d;
  logic [tfb_pkg::CountWidth-1:0]   seen_q, seen_d;
  logic [15:0]                      decl_q, decl_d;
  logic                             out_vld_q, out_vld_d;
  logic [7:0]                       byte_q, byte_d;
  logic                             end_q, end_d, err_q, err_d;
  logic                             load, emit, checked;
  logic [7:0]                       b, sum_base, add_base;
  tfb_pkg::item_t                   it;

  assign it   = held_i.item;
  assign load = ~out_vld_q | ~out_stall_i;

  always_comb begin
    cur = slot_q;
    if (slot_q == S_START) begin
      if (!in_frame_q)             cur = S_HDR0;
      else if (it.has_byte)        cur = S_DATA;
      else if (it.end_of_payload)  cur = S_SUM;
      else                         cur = S_NONE;
    end
  end

  always_comb begin
    case (cur)
      S_HDR0: nxt = S_HDR1;
      S_HDR1: nxt = S_HDR2;
      S_HDR2: nxt = S_HDR3;
      S_HDR3: nxt = S_HDR4;
      S_HDR4: nxt = S_HDR5;
      S_HDR5: nxt = it.has_byte ? S_DATA : (it.end_of_payload ? S_SUM : S_NONE);
      S_DATA: nxt = it.end_of_payload ? S_SUM : S_NONE;
      S_SUM:  nxt = S_ADD;
      default: nxt = S_NONE;
    endcase
  end

  assign emit   = held_i.vld & (cur != S_NONE) & load;
  assign done_o = held_i.vld & ((cur == S_NONE) | (emit & (nxt == S_NONE)));

  always_comb begin
    checked = 1'b1;
    case (cur)
      S_HDR0: b = cfg_i.head_byte;
      S_HDR1: b = cfg_i.src_addr;
      S_HDR2: b = cfg_i.dst_addr;
      S_HDR3: b = it.func_code;
      S_HDR4: b = it.payload_len[7:0];
      S_HDR5: b = it.payload_len[15:8];
      S_DATA: b = it.data_byte;
      S_SUM: begin
        b       = sum_q;
        checked = 1'b0;
      end
      S_ADD: begin
        b       = add_q;
        checked = 1'b0;
      end
      default: begin
        b       = 8'd0;
        checked = 1'b0;
      end
    endcase
  end

  assign sum_base = (cur == S_HDR0) ? 8'd0 : sum_q;
  assign add_base = (cur == S_HDR0) ? 8'd0 : add_q;

  always_comb begin
    slot_d     = slot_q;
    in_frame_d = in_frame_q;
    sum_d      = sum_q;
    add_d      = add_q;
    seen_d     = seen_q;
    decl_d     = decl_q;
    out_vld_d  = out_vld_q & out_stall_i;
    byte_d     = byte_q;
    end_d      = end_q;
    err_d      = err_q;

    if (emit) begin
      out_vld_d = 1'b1;
      byte_d    = b;
      end_d     = (cur == S_ADD);
      err_d     = (cur == S_ADD) && (seen_q != {1'b0, decl_q});
      slot_d    = nxt;
      if (checked) begin
        sum_d = sum_base + b;
        add_d = add_base + sum_d;
      end
      if (cur == S_HDR0) begin
        in_frame_d = 1'b1;
        seen_d     = '0;
        decl_d     = it.payload_len;
      end
      if ((cur == S_DATA) && (seen_q != '1)) begin
        seen_d = seen_q + 1'b1;
      end
      if (cur == S_ADD) begin
        in_frame_d = 1'b0;
        sum_d      = 8'd0;
        add_d      = 8'd0;
        seen_d     = '0;
        decl_d     = 16'd0;
      end
    end

    if (done_o) begin
      slot_d = S_START;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q     <= S_START;
      in_frame_q <= 1'b0;
      sum_q      <= 8'd0;
      add_q      <= 8'd0;
      seen_q     <= '0;
      decl_q     <= 16'd0;
      out_vld_q  <= 1'b0;
    end else begin
      slot_q     <= slot_d;
      in_frame_q <= in_frame_d;
      sum_q      <= sum_d;
      add_q      <= add_d;
      seen_q     <= seen_d;
      decl_q     <= decl_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    end_q  <= end_d;
    err_q  <= err_d;
  end

  assign out_valid_o    = out_vld_q;
  assign out_byte_o     = byte_q;
  assign frame_end_o    = end_q;
  assign length_error_o = err_q;

endmodule

/* design/telemetry_frame_builder_dual_checksum.sv */
// channel  | direction | handshake                | payload
// in       | input     | in_valid_i / in_stall_o  | func_code, payload_len, data_byte,
//          |           |                          | has_byte, end_of_payload
// out      | output    | out_valid_o / out_stall_i| out_byte, frame_end, length_error
// cfg      | input     | APB psel/penable/pready  | head_byte, src_addr, dst_addr
//
// One result byte leaves per cycle while out_stall_i is low; an item causes up to three
// result bytes mid-frame, six to nine when it opens a frame.
// The byte sequencer walks the held item's slots into a single output register.
// Input is stalled while the held item still has bytes left to emit.
// rst_ni clears frame state, checks and valids; head_byte resets to 0xAB.
module telemetry_frame_builder_dual_checksum (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tfb_pkg::PaddrWidth-1:0] paddr,
  input  logic [tfb_pkg::PdataWidth-1:0] pwdata,
  output logic [tfb_pkg::PdataWidth-1:0] prdata,
  output logic                           pready,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [7:0]                     func_code_i,
  input  logic [15:0]                    payload_len_i,
  input  logic [7:0]                     data_byte_i,
  input  logic                           has_byte_i,
  input  logic                           end_of_payload_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [7:0]                     out_byte_o,
  output logic                           frame_end_o,
  output logic                           length_error_o
);

  tfb_pkg::cfg_t  cfg;
  tfb_pkg::item_t item;
  tfb_pkg::held_t held;
  logic           done;

  assign item.func_code      = func_code_i;
  assign item.payload_len    = payload_len_i;
  assign item.data_byte      = data_byte_i;
  assign item.has_byte       = has_byte_i;
  assign item.end_of_payload = end_of_payload_i;

  tfb_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tfb_in_reg u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (item),
    .done_i     (done),
    .held_o     (held)
  );

  tfb_framer u_framer (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .held_i         (held),
    .done_o         (done),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_byte_o     (out_byte_o),
    .frame_end_o    (frame_end_o),
    .length_error_o (length_error_o)
  );

endmodule

/* design/tfb_checker.sv */
module tfb_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       psel,
  input logic       penable,
  input logic       pready,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_byte_o,
  input logic       frame_end_o,
  input logic       length_error_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o)
      && $stable(frame_end_o) && $stable(length_error_o))
    else $error("stalled result changed");

  a_err_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && length_error_o |-> frame_end_o)
    else $error("length error outside frame end");

  a_no_double_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && frame_end_o |=> !(out_valid_o && frame_end_o))
    else $error("frame end on consecutive results");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable |-> pready)
    else $error("access cycle without ready");

endmodule

bind telemetry_frame_builder_dual_checksum tfb_checker u_tfb_checker (.*);
